// ===== hw/rtl/fnt_pkg.sv =====
// Package for the next-toward block: item types shared by the interfaces and the datapath,
// format codes, field masks and the helper functions of the datapath.
// Depends on nothing.
`default_nettype none

package fnt_pkg;

    typedef enum logic [1:0] {
        FMT_SGL = 2'd0,
        FMT_DBL = 2'd1,
        FMT_EXT = 2'd2,
        FMT_RAW = 2'd3
    } t_fmt;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] x_top;
        logic [63:0] x_bits;
        logic [15:0] y_top;
        logic [63:0] y_bits;
    } t_in_item;

    typedef struct packed {
        logic [15:0] result_top;
        logic [63:0] result_bits;
    } t_out_item;

    localparam int KeyHiW = 17;
    localparam int KeyW   = KeyHiW + 64;
    localparam int StepW  = 79;

    localparam logic [14:0]       ExtExpMax = 15'h7FFF;
    localparam logic [KeyHiW-1:0] KeyHiInf  = {KeyHiW{1'b1}};
    localparam logic [KeyHiW-1:0] KeyHiBias = KeyHiW'(64);

    // Leading zero count of a 64-bit word, done per byte and then across bytes.
    function automatic logic [5:0] lzc64(input logic [63:0] b);
        logic [7:0] by;
        logic [7:0] nz;
        logic [2:0] bl [8];
        logic [5:0] r;
        for (int g = 0; g < 8; g++) begin
            by    = b[63-8*g -: 8];
            nz[g] = |by;
            bl[g] = 3'd0;
            for (int j = 0; j < 8; j++) begin
                if (by[j]) begin
                    bl[g] = 3'(7 - j);
                end
            end
        end
        r = 6'd0;
        for (int g = 7; g >= 0; g--) begin
            if (nz[g]) begin
                r = {3'(g), bl[g]};
            end
        end
        return r;
    endfunction

    function automatic logic op_nan(input logic [1:0] fmt, input logic [15:0] top,
                                    input logic [63:0] bits);
        logic r;
        case (fmt)
            FMT_SGL: r = (bits[30:23] == 8'hFF) && (bits[22:0] != '0);
            FMT_DBL: r = (bits[62:52] == 11'h7FF) && (bits[51:0] != '0);
            default: r = (top[14:0] == ExtExpMax) && (bits[62:0] != '0);
        endcase
        return r;
    endfunction

    function automatic logic op_zero(input logic [1:0] fmt, input logic [15:0] top,
                                     input logic [63:0] bits);
        logic r;
        case (fmt)
            FMT_SGL: r = (bits[30:0] == '0);
            FMT_DBL: r = (bits[62:0] == '0);
            default: r = (top[14:0] != ExtExpMax) && (bits == '0);
        endcase
        return r;
    endfunction

    function automatic logic op_neg(input logic [1:0] fmt, input logic [15:0] top,
                                    input logic [63:0] bits);
        logic r;
        case (fmt)
            FMT_SGL: r = bits[31];
            FMT_DBL: r = bits[63];
            default: r = top[15];
        endcase
        return r;
    endfunction

    // Magnitude key: for extended, normalised exponent above and significand below; else raw bits.
    function automatic logic [KeyW-1:0] op_key(input logic [1:0] fmt, input logic [15:0] top,
                                               input logic [63:0] bits, input logic [5:0] lz);
        logic [KeyHiW-1:0] hi;
        logic [14:0]       e;
        logic [63:0]       lo;
        e  = top[14:0];
        hi = '0;
        lo = '0;
        case (fmt)
            FMT_SGL: lo = {33'd0, bits[30:0]};
            FMT_DBL: lo = {1'b0, bits[62:0]};
            default: begin
                if (e == ExtExpMax) begin
                    hi = KeyHiInf;
                end else begin
                    hi = KeyHiW'((e == 15'd0) ? 15'd1 : e) + KeyHiBias - KeyHiW'(lz);
                    lo = bits << lz;
                end
            end
        endcase
        return {hi, lo};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fnt_in_if.sv =====
// Input channel of the next-toward block: valid, ready and one operand item.
// Depends on fnt_pkg.
`default_nettype none

interface fnt_in_if
    import fnt_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fnt_out_if.sv =====
// Output channel of the next-toward block: valid, ready and one result item.
// Depends on fnt_pkg.
`default_nettype none

interface fnt_out_if
    import fnt_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/float_next_toward.sv =====
// Top level of the next-toward block: five-stage pipeline for single, double and
// extended operands, raw items passing x through. Depends on fnt_pkg, fnt_in_if and fnt_out_if.
//
//  Channel  Dir  Port   Item
//  in       in   i_in   op, x_top, x_bits, y_top, y_bits
//  out      out  o_out  result_top, result_bits
//
// One item is taken each cycle unless every stage is full and the output is stalled; each result passes
// the input, count, key and decision registers before it is offered from the output register.
// Stages: input register, leading zero count, classification and keys, compare
// and selection, 79-bit step into the output register.
// Every stage holds its own valid bit and advances whenever the stage after it
// is empty or moving, so bubbles close up while the output is stalled.
// Reset clears the valid bits only.
`default_nettype none

module float_next_toward
    import fnt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fnt_in_if.sink     i_in,
    fnt_out_if.source  o_out
);

    typedef struct packed {
        logic [5:0] lz_x;
        logic [5:0] lz_y;
    } t_lz;

    typedef struct packed {
        logic            nan;
        logic            zero;
        logic            neg;
        logic [KeyW-1:0] key;
    } t_cls;

    typedef struct packed {
        logic            step;
        logic            up;
        logic            intbit;
        logic [1:0]      fmt;
        logic [StepW-1:0] v;
        t_out_item       res;
    } t_dec;

    logic      r_v1, r_v2, r_v3, r_v4, r_v5;
    logic      en1, en2, en3, en4, en5;
    t_in_item  r_s1, n_s1, r_s2, r_s3;
    t_lz       r_lz2, n_lz2;
    t_cls      r_cx3, r_cy3, n_cx3, n_cy3;
    t_dec      r_d4, n_d4;
    t_out_item r_out, n_out;
    logic [StepW-1:0] w;

    assign en5 = !r_v5 || o_out.ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_in.ready  = en1;
    assign o_out.valid = r_v5;
    assign o_out.data  = r_out;

    always_comb begin
        n_s1 = i_in.data;
        if (i_in.data.op == FMT_SGL) begin
            n_s1.x_bits = {32'd0, i_in.data.x_bits[31:0]};
            n_s1.y_bits = {32'd0, i_in.data.y_bits[31:0]};
        end
        if (i_in.data.op == FMT_SGL || i_in.data.op == FMT_DBL) begin
            n_s1.x_top = '0;
            n_s1.y_top = '0;
        end
    end

    assign n_lz2.lz_x = lzc64(r_s1.x_bits);
    assign n_lz2.lz_y = lzc64(r_s1.y_bits);

    always_comb begin
        n_cx3.nan  = op_nan(r_s2.op, r_s2.x_top, r_s2.x_bits);
        n_cx3.zero = op_zero(r_s2.op, r_s2.x_top, r_s2.x_bits);
        n_cx3.neg  = op_neg(r_s2.op, r_s2.x_top, r_s2.x_bits);
        n_cx3.key  = op_key(r_s2.op, r_s2.x_top, r_s2.x_bits, r_lz2.lz_x);
        n_cy3.nan  = op_nan(r_s2.op, r_s2.y_top, r_s2.y_bits);
        n_cy3.zero = op_zero(r_s2.op, r_s2.y_top, r_s2.y_bits);
        n_cy3.neg  = op_neg(r_s2.op, r_s2.y_top, r_s2.y_bits);
        n_cy3.key  = op_key(r_s2.op, r_s2.y_top, r_s2.y_bits, r_lz2.lz_y);
    end

    always_comb begin
        logic [1:0] rk_x;
        logic [1:0] rk_y;
        logic       eq;
        logic       lt;
        logic       mlt;
        logic       mgt;
        rk_x = r_cx3.zero ? 2'd1 : (r_cx3.neg ? 2'd0 : 2'd2);
        rk_y = r_cy3.zero ? 2'd1 : (r_cy3.neg ? 2'd0 : 2'd2);
        mlt  = r_cx3.key < r_cy3.key;
        mgt  = r_cx3.key > r_cy3.key;
        if (rk_x != rk_y) begin
            eq = 1'b0;
            lt = rk_x < rk_y;
        end else if (rk_x == 2'd1) begin
            eq = 1'b1;
            lt = 1'b0;
        end else begin
            eq = !mlt && !mgt;
            lt = (rk_x == 2'd2) ? mlt : mgt;
        end

        n_d4.up     = lt != r_cx3.neg;
        n_d4.intbit = r_s3.x_bits[63];
        n_d4.fmt    = r_s3.op;
        n_d4.step   = 1'b0;
        n_d4.res    = {r_s3.x_top, r_s3.x_bits};
        case (r_s3.op)
            FMT_SGL: n_d4.v = {48'd0, r_s3.x_bits[30:0]};
            FMT_DBL: n_d4.v = {16'd0, r_s3.x_bits[62:0]};
            default: n_d4.v = {r_s3.x_top[14:0],
                               (r_s3.x_bits[63] && !n_d4.up) ? 1'b0 : r_s3.x_bits[63],
                               r_s3.x_bits[62:0]};
        endcase

        if (r_s3.op == FMT_RAW || r_cx3.nan && !r_cy3.nan || eq && !r_cy3.nan) begin
            n_d4.res = {r_s3.x_top, r_s3.x_bits};
        end else if (r_cy3.nan) begin
            n_d4.res = {r_s3.y_top, r_s3.y_bits};
        end else if (r_cx3.zero) begin
            case (r_s3.op)
                FMT_SGL: n_d4.res = {16'd0, 32'd0, r_cy3.neg, 31'd1};
                FMT_DBL: n_d4.res = {16'd0, r_cy3.neg, 63'd1};
                default: n_d4.res = {r_cy3.neg, 15'd0, 64'd1};
            endcase
        end else begin
            n_d4.step = 1'b1;
        end
    end

    assign w = r_d4.up ? r_d4.v + StepW'(1) : r_d4.v - StepW'(1);

    always_comb begin
        n_out = r_d4.res;
        if (r_d4.step) begin
            case (r_d4.fmt)
                FMT_SGL: n_out = {16'd0, 32'd0, r_d4.res.result_bits[31], w[30:0]};
                FMT_DBL: n_out = {16'd0, r_d4.res.result_bits[63], w[62:0]};
                default: n_out = {r_d4.res.result_top[15], w[78:64],
                                  w[63] | r_d4.intbit, w[62:0]};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
            if (en5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= n_s1;
        end
        if (en2) begin
            r_s2  <= r_s1;
            r_lz2 <= n_lz2;
        end
        if (en3) begin
            r_s3  <= r_s2;
            r_cx3 <= n_cx3;
            r_cy3 <= n_cy3;
        end
        if (en4) begin
            r_d4 <= n_d4;
        end
        if (en5) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
